// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on clk, switched off while rst_n is low
`define PIP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next
`define PIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pip_pkg.sv
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int RAY_END_X    = 10000;
    localparam int MIN_POLY     = 3;

    localparam int COORD_W = 14;
    localparam int CNT_W   = 7;
    localparam int SLOT_W  = 6;
    localparam int IDX_W   = $clog2(MAX_VERTICES);
    localparam int N_W     = ($clog2(MAX_VERTICES + 1) > CNT_W) ?
                             $clog2(MAX_VERTICES + 1) : CNT_W;

    // coordinate differences, and the far end minus the lowest coordinate
    localparam int DIFF_W  = COORD_W + 1;
    localparam int FAR_W   = 17;
    localparam int PROD_W  = DIFF_W + FAR_W;
    localparam int CROSS_W = PROD_W + 1;

    localparam logic signed [FAR_W-1:0] FAR_X = FAR_W'(RAY_END_X);

    // edge evaluator depth after the last edge leaves the ring
    localparam int DRAIN_CYCLES = 2;

    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = '0;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vertex_t;

    typedef struct packed {
        logic    valid;
        vertex_t a;
        vertex_t b;
        vertex_t p;
    } edge_req_t;

    typedef struct packed {
        logic inside_res;
        logic on_boundary;
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        TURN_COLL,
        TURN_CW,
        TURN_CCW
    } turn_t;

endpackage

// File: rtl/core/pip_if.sv
interface pip_in_if import pip_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [SLOT_W-1:0] vertex_index;
    coord_t            coord_x;
    coord_t            coord_y;

    modport source (output valid, mode, vertex_index, coord_x, coord_y, input ready);
    modport sink   (input valid, mode, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pip_out_if import pip_pkg::*; ();
    logic valid;
    logic ready;
    logic inside_res;
    logic on_boundary;

    modport source (output valid, inside_res, on_boundary, input ready);
    modport sink   (input valid, inside_res, on_boundary, output ready);
endinterface

// File: rtl/core/point_in_polygon_test_unit.sv
// Vertex load: one request per cycle while idle, no result; loads wait while a query runs.
// Query: the result is registered in the done state after the vertex ring rotates once through
// all 64 cells, one edge per cycle, into a three-stage evaluator, and the evaluator drains.
// A new request is taken only once the previous query's result is loaded into the output;
// the next request is taken while a result waits.
// Reset: rst_n, asynchronous, active low, clears the FSM, vertex_count and the result valid;
// vertex cells are not reset and hold no defined value until loaded.
`include "assert_macros.svh"

module point_in_polygon_test_unit import pip_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    pip_in_if.sink             item,
    pip_out_if.source          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    localparam logic [N_W-1:0]   MAX_N  = N_W'(MAX_VERTICES);
    localparam logic [IDX_W-1:0] K_LAST = IDX_W'(MAX_VERTICES - 1);
    localparam logic             DRAIN_LAST = 1'(DRAIN_CYCLES - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             drain_reg, drain_next;
    logic [CNT_W-1:0] vcount_reg, vcount_next;
    vertex_t          query_reg, v0_reg;
    logic             out_valid_reg, out_valid_next;
    verdict_t         out_verdict_reg;

    logic             accept, load_acc, query_acc;
    logic             sweep, out_load;
    logic             cfg_write, cfg_hit;
    logic [N_W-1:0]   n, k_ext;
    vertex_t          item_vertex;
    vertex_t          ring [MAX_VERTICES];
    edge_req_t        edge_req;
    verdict_t         verdict;

    assign item_vertex = '{x: item.coord_x, y: item.coord_y};
    assign accept      = item.valid && item.ready;
    assign load_acc    = accept && (item.mode == MODE_LOAD);
    assign query_acc   = accept && (item.mode == MODE_QUERY);

    // ring of vertex cells; rotates one place per sweep cycle, home again after a full turn
    for (genvar i = 0; i < MAX_VERTICES; i++)
    begin : g_cell
        pip_vertex_cell u_cell (
            .clk          (clk),
            .load         (load_acc && (32'(item.vertex_index) == i)),
            .load_vertex  (item_vertex),
            .shift        (sweep),
            .shift_vertex (ring[(i + 1) % MAX_VERTICES]),
            .vertex       (ring[i])
        );
    end

    assign n     = (N_W'(vcount_reg) > MAX_N) ? MAX_N : N_W'(vcount_reg);
    assign k_ext = N_W'(k_reg);

    always_comb
    begin
        edge_req.valid = sweep && (k_ext < n) && (n >= N_W'(MIN_POLY));
        edge_req.a     = ring[0];
        // closing edge joins the last vertex back to the first
        edge_req.b     = (k_ext == n - N_W'(1)) ? v0_reg : ring[1];
        edge_req.p     = query_reg;
    end

    pip_edge_eval u_eval (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (query_acc),
        .req     (edge_req),
        .verdict (verdict)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_acc)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (k_reg == K_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == DRAIN_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item.ready = 1'b0;
        sweep      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item.ready = 1'b1;
            end
            ST_SWEEP:
            begin
                sweep = 1'b1;
            end
            ST_DRAIN:
            begin
                out_load = 1'b0;
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || result.ready;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        k_next     = (sweep && (k_reg != K_LAST)) ? k_reg + IDX_W'(1) : '0;
        drain_next = (state_reg == ST_DRAIN) ? !drain_reg : 1'b0;

        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign cfg_write   = psel && penable && pwrite && pready;
    assign cfg_hit     = paddr[PADDR_W-1:2] == REG_VERTEX_COUNT;
    assign vcount_next = (cfg_write && cfg_hit) ? pwdata[CNT_W-1:0] : vcount_reg;
    assign prdata      = cfg_hit ? DATA_W'(vcount_reg) : '0;
    assign pready      = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            drain_reg     <= 1'b0;
            vcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            drain_reg     <= drain_next;
            vcount_reg    <= vcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_acc)
        begin
            query_reg <= item_vertex;
            v0_reg    <= ring[0];
        end
        if (out_load)
        begin
            out_verdict_reg <= verdict;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.inside_res  = out_verdict_reg.inside_res;
    assign result.on_boundary = out_verdict_reg.on_boundary;

    `PIP_ASSERT_NEXT(a_query_starts_sweep, query_acc, (state_reg == ST_SWEEP) && (k_reg == '0), "query did not start a sweep at the ring head")
    `PIP_ASSERT_NEXT(a_sweep_full_turn, (state_reg == ST_SWEEP) && (k_reg == K_LAST), state_reg == ST_DRAIN, "sweep did not end after a full ring turn")
    `PIP_ASSERT(a_result_after_done, $rose(out_valid_reg) |-> $past(state_reg == ST_DONE), "result raised outside the done state")

endmodule

// File: rtl/core/pip_vertex_cell.sv
module pip_vertex_cell import pip_pkg::*; (
    input  logic    clk,
    input  logic    load,
    input  vertex_t load_vertex,
    input  logic    shift,
    input  vertex_t shift_vertex,
    output vertex_t vertex
);

    vertex_t vertex_reg;
    vertex_t vertex_next;

    always_comb
    begin
        priority if (load)
        begin
            vertex_next = load_vertex;
        end
        else if (shift)
        begin
            vertex_next = shift_vertex;
        end
        else
        begin
            vertex_next = vertex_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        vertex_reg <= vertex_next;
    end

    assign vertex = vertex_reg;

endmodule

// File: rtl/core/pip_edge_eval.sv
module pip_edge_eval import pip_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  edge_req_t req,
    output verdict_t  verdict
);

    function automatic turn_t to_turn(input logic signed [CROSS_W-1:0] v);
        turn_t t;
        if (v == '0)
        begin
            t = TURN_COLL;
        end
        else if (v[CROSS_W-1])
        begin
            t = TURN_CCW;
        end
        else
        begin
            t = TURN_CW;
        end
        return t;
    endfunction

    // stage 1: differences and the comparisons that need no product
    logic                      s1_valid_reg;
    logic signed [DIFF_W-1:0]  dby_reg, dbx_reg, dpx_reg, dpy_reg;
    logic signed [FAR_W-1:0]   dfx_reg;
    logic                      s1_box_reg, s1_a_right_reg, s1_b_right_reg;
    turn_t                     s1_t3_reg, s1_t4_reg;

    logic                      box_next;
    turn_t                     t3_next, t4_next;

    // stage 2: products
    logic                      s2_valid_reg;
    logic signed [PROD_W-1:0]  m1_reg, m2_reg, m3_reg;
    logic                      s2_box_reg, s2_a_right_reg, s2_b_right_reg;
    turn_t                     s2_t3_reg, s2_t4_reg;

    // stage 3: edge decision and the running verdict
    logic signed [CROSS_W-1:0] v1, v2;
    turn_t                     t1, t2;
    logic                      meet;
    logic                      decided_reg, decided_next;
    logic                      hit_reg, hit_next;
    logic                      parity_reg, parity_next;

    always_comb
    begin
        box_next = ((req.p.x >= req.a.x) && (req.p.x <= req.b.x) ||
                    (req.p.x >= req.b.x) && (req.p.x <= req.a.x)) &&
                   ((req.p.y >= req.a.y) && (req.p.y <= req.b.y) ||
                    (req.p.y >= req.b.y) && (req.p.y <= req.a.y));

        // orientation against the ray reduces to the sign of the y offset
        if (req.a.y < req.p.y)
        begin
            t3_next = TURN_CW;
        end
        else if (req.a.y > req.p.y)
        begin
            t3_next = TURN_CCW;
        end
        else
        begin
            t3_next = TURN_COLL;
        end

        if (req.b.y < req.p.y)
        begin
            t4_next = TURN_CW;
        end
        else if (req.b.y > req.p.y)
        begin
            t4_next = TURN_CCW;
        end
        else
        begin
            t4_next = TURN_COLL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dby_reg        <= DIFF_W'(req.b.y) - DIFF_W'(req.a.y);
        dbx_reg        <= DIFF_W'(req.b.x) - DIFF_W'(req.a.x);
        dpx_reg        <= DIFF_W'(req.p.x) - DIFF_W'(req.b.x);
        dpy_reg        <= DIFF_W'(req.p.y) - DIFF_W'(req.b.y);
        dfx_reg        <= FAR_X - FAR_W'(req.b.x);
        s1_box_reg     <= box_next;
        s1_t3_reg      <= t3_next;
        s1_t4_reg      <= t4_next;
        s1_a_right_reg <= req.a.x >= req.p.x;
        s1_b_right_reg <= req.b.x >= req.p.x;

        m1_reg         <= PROD_W'(dby_reg) * PROD_W'(dpx_reg);
        m2_reg         <= PROD_W'(dbx_reg) * PROD_W'(dpy_reg);
        m3_reg         <= PROD_W'(dby_reg) * PROD_W'(dfx_reg);
        s2_box_reg     <= s1_box_reg;
        s2_t3_reg      <= s1_t3_reg;
        s2_t4_reg      <= s1_t4_reg;
        s2_a_right_reg <= s1_a_right_reg;
        s2_b_right_reg <= s1_b_right_reg;
    end

    // the far end lies beyond every coordinate, so it never sits on an edge
    always_comb
    begin
        v1   = CROSS_W'(m1_reg) - CROSS_W'(m2_reg);
        v2   = CROSS_W'(m3_reg) - CROSS_W'(m2_reg);
        t1   = to_turn(v1);
        t2   = to_turn(v2);
        meet = ((t1 != t2) && (s2_t3_reg != s2_t4_reg)) ||
               ((t1 == TURN_COLL) && s2_box_reg) ||
               ((s2_t3_reg == TURN_COLL) && s2_a_right_reg) ||
               ((s2_t4_reg == TURN_COLL) && s2_b_right_reg);
    end

    always_comb
    begin
        decided_next = decided_reg;
        hit_next     = hit_reg;
        parity_next  = parity_reg;
        priority if (start)
        begin
            decided_next = 1'b0;
            hit_next     = 1'b0;
            parity_next  = 1'b0;
        end
        else if (s2_valid_reg && !decided_reg && meet)
        begin
            // point collinear with a crossing edge: settle the verdict here; any other crossing flips the parity
            if (t1 == TURN_COLL)
            begin
                decided_next = 1'b1;
                hit_next     = s2_box_reg;
            end
            else
            begin
                parity_next = !parity_reg;
            end
        end
        else
        begin
            decided_next = decided_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decided_reg <= 1'b0;
            hit_reg     <= 1'b0;
            parity_reg  <= 1'b0;
        end
        else
        begin
            decided_reg <= decided_next;
            hit_reg     <= hit_next;
            parity_reg  <= parity_next;
        end
    end

    assign verdict.inside_res  = decided_reg ? hit_reg : parity_reg;
    assign verdict.on_boundary = decided_reg;

endmodule

// File: dv/point_in_polygon_test_unit_test.sv
`timescale 1ns / 1ps

module point_in_polygon_test_unit_test;
    import pip_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int ITEM_TARGET    = 1200;
    localparam int SETTLE_CYCLES  = MAX_VERTICES + 3 + DRAIN_CYCLES + 6;
    localparam int HOLD_OFF       = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [PADDR_W-1:0] VCOUNT_ADDR = {REG_VERTEX_COUNT, 2'b00};

    localparam verdict_t V_OUTSIDE  = '{inside_res: 1'b0, on_boundary: 1'b0};
    localparam verdict_t V_INSIDE   = '{inside_res: 1'b1, on_boundary: 1'b0};
    localparam verdict_t V_ON_EDGE  = '{inside_res: 1'b1, on_boundary: 1'b1};
    localparam verdict_t V_OFF_EDGE = '{inside_res: 1'b0, on_boundary: 1'b1};

    typedef enum logic [1:0] {
        STEP_SET_COUNT,
        STEP_LOAD,
        STEP_QUERY
    } step_kind_t;

    typedef struct {
        step_kind_t kind;
        int         value;
        int         slot;
        int         x;
        int         y;
        bit         pinned;
        verdict_t   verdict;
    } script_row_t;

    typedef struct {
        logic              mode;
        logic [SLOT_W-1:0] slot;
        coord_t            x;
        coord_t            y;
        bit                pinned;
        verdict_t          verdict;
    } request_t;

    typedef struct {
        longint x;
        longint y;
    } xy_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    pip_in_if  item_ch ();
    pip_out_if result_ch ();

    point_in_polygon_test_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // polygon mirror and vertex count as the block should hold them
    coord_t           vx_mem [MAX_VERTICES];
    coord_t           vy_mem [MAX_VERTICES];
    logic [CNT_W-1:0] poly_size = '0;

    request_t    pending_q [$];
    verdict_t    verdicts_due [$];
    script_row_t script [$];

    int fault_cnt     = 0;
    int items_queued  = 0;
    int loads_seen    = 0;
    int queries_seen  = 0;
    int edge_verdicts = 0;
    int settings_seen = 0;
    int quiet_cycles  = 0;

    bit          gaps_on      = 1'b1;
    int          sink_style   = 1;
    logic [15:0] sink_mask    = 16'hffff;
    bit          hold_off_req = 1'b0;
    int          hold_left    = 0;
    logic [3:0]  tick         = '0;
    int          burst_left   = 0;
    int          gap_left     = 0;

    function automatic void note_fault(string msg);
        fault_cnt++;
        if (fault_cnt <= REPORT_LIMIT)
            $display("%0t ns: %s", $time, msg);
    endfunction

    function automatic turn_t orient(xy_t a, xy_t b, xy_t c);
        longint v;
        v = (b.y - a.y) * (c.x - b.x) - (b.x - a.x) * (c.y - b.y);
        if (v == 0)
            return TURN_COLL;
        return (v > 0) ? TURN_CW : TURN_CCW;
    endfunction

    // q inside the bounding box of a-c
    function automatic bit in_box(xy_t a, xy_t q, xy_t c);
        return q.x <= ((a.x > c.x) ? a.x : c.x) && q.x >= ((a.x < c.x) ? a.x : c.x) &&
               q.y <= ((a.y > c.y) ? a.y : c.y) && q.y >= ((a.y < c.y) ? a.y : c.y);
    endfunction

    function automatic bit segments_touch(xy_t a, xy_t b, xy_t p, xy_t f);
        turn_t t1, t2, t3, t4;
        t1 = orient(a, b, p);
        t2 = orient(a, b, f);
        t3 = orient(p, f, a);
        t4 = orient(p, f, b);
        if (t1 != t2 && t3 != t4)
            return 1'b1;
        if (t1 == TURN_COLL && in_box(a, p, b)) return 1'b1;
        if (t2 == TURN_COLL && in_box(a, f, b)) return 1'b1;
        if (t3 == TURN_COLL && in_box(p, a, f)) return 1'b1;
        if (t4 == TURN_COLL && in_box(p, b, f)) return 1'b1;
        return 1'b0;
    endfunction

    // crossing parity of the ray towards the far end, or the on-edge decision
    function automatic verdict_t predict_verdict(coord_t qx, coord_t qy);
        verdict_t v;
        xy_t      p, f, a, b;
        int       n, i, j, hits;
        v    = V_OUTSIDE;
        hits = 0;
        n    = (int'(poly_size) > MAX_VERTICES) ? MAX_VERTICES : int'(poly_size);
        if (n < MIN_POLY)
            return v;
        p.x = qx;
        p.y = qy;
        f.x = RAY_END_X;
        f.y = qy;
        for (i = 0; i < n; i++) begin
            j   = (i + 1 == n) ? 0 : i + 1;
            a.x = vx_mem[i];
            a.y = vy_mem[i];
            b.x = vx_mem[j];
            b.y = vy_mem[j];
            if (segments_touch(a, b, p, f)) begin
                if (orient(a, p, b) == TURN_COLL) begin
                    v.inside_res  = in_box(a, p, b);
                    v.on_boundary = 1'b1;
                    return v;
                end
                hits++;
            end
        end
        v.inside_res = hits[0];
        return v;
    endfunction

    function automatic void take_request(request_t r);
        verdict_t v;
        if (r.mode == MODE_LOAD) begin
            vx_mem[r.slot] = r.x;
            vy_mem[r.slot] = r.y;
            loads_seen++;
        end else begin
            v = r.pinned ? r.verdict : predict_verdict(r.x, r.y);
            verdicts_due.push_back(v);
            queries_seen++;
            if (v.on_boundary)
                edge_verdicts++;
        end
    endfunction

    function automatic void enqueue(logic mode, int slot, coord_t x, coord_t y);
        request_t r;
        r.mode    = mode;
        r.slot    = SLOT_W'(slot);
        r.x       = x;
        r.y       = y;
        r.pinned  = 1'b0;
        r.verdict = V_OUTSIDE;
        pending_q.push_back(r);
        items_queued++;
    endfunction

    function automatic void add_step(step_kind_t kind, int value, int slot, int x, int y,
                                     bit pinned, verdict_t verdict);
        script_row_t s;
        s.kind    = kind;
        s.value   = value;
        s.slot    = slot;
        s.x       = x;
        s.y       = y;
        s.pinned  = pinned;
        s.verdict = verdict;
        script.push_back(s);
    endfunction

    function automatic coord_t rand_coord(int span);
        if (span >= 8191) begin
            case ($urandom_range(0, 9))
                0:       return coord_t'(-8192);
                1:       return coord_t'(8191);
                default: return coord_t'(int'($urandom_range(0, 16383)) - 8192);
            endcase
        end
        return coord_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic int pick_vertex_count();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return $urandom_range(3, 12);
        if (roll == 7)
            return $urandom_range(13, 64);
        if (roll == 8)
            return $urandom_range(65, 127);
        return $urandom_range(0, 2);
    endfunction

    // request source: bursts with gaps while gaps_on is set, valid held until taken
    always @(posedge clk) begin
        if (!rst_n) begin
            item_ch.valid        <= 1'b0;
            item_ch.mode         <= MODE_LOAD;
            item_ch.vertex_index <= '0;
            item_ch.coord_x      <= '0;
            item_ch.coord_y      <= '0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                take_request(pending_q.pop_front());
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    if (!gaps_on)
                        gap_left = 0;
                    else if ($urandom_range(0, 9) == 0)
                        gap_left = $urandom_range(20, 90);
                    else
                        gap_left = $urandom_range(0, 6);
                end
            end
            if (!(item_ch.valid && !item_ch.ready)) begin
                if (gap_left > 0 || pending_q.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    item_ch.valid <= 1'b0;
                end else begin
                    item_ch.valid        <= 1'b1;
                    item_ch.mode         <= pending_q[0].mode;
                    item_ch.vertex_index <= pending_q[0].slot;
                    item_ch.coord_x      <= pending_q[0].x;
                    item_ch.coord_y      <= pending_q[0].y;
                end
            end
        end
    end

    // verdict sink: check, then pick the next ready level
    always @(posedge clk) begin
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (verdicts_due.size() == 0) begin
                    note_fault($sformatf("verdict inside=%b on_boundary=%b with none due",
                                         result_ch.inside_res, result_ch.on_boundary));
                end else if (result_ch.inside_res !== verdicts_due[0].inside_res ||
                             result_ch.on_boundary !== verdicts_due[0].on_boundary) begin
                    note_fault($sformatf("verdict mismatch: expected inside=%b on_boundary=%b, got inside=%b on_boundary=%b",
                                         verdicts_due[0].inside_res, verdicts_due[0].on_boundary,
                                         result_ch.inside_res, result_ch.on_boundary));
                    void'(verdicts_due.pop_front());
                end else begin
                    void'(verdicts_due.pop_front());
                end
            end
            if (hold_off_req) begin
                hold_left    = HOLD_OFF;
                hold_off_req = 1'b0;
            end
            tick = tick + 1'b1;
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                case (sink_style)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: result_ch.ready <= sink_mask[tick];
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Watchdog: no handshake for %0d cycles, %0d verdicts outstanding",
                 WATCHDOG_LIMIT, verdicts_due.size());
        $display("Simulation FAILED");
        $finish;
    end

    // drain the block, then let any trailing work settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || verdicts_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write vertex_count, then read it back
    task automatic set_vertex_count(int value);
        logic [DATA_W-1:0] got;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= VCOUNT_ADDR;
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        poly_size = CNT_W'(value);
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== DATA_W'(poly_size))
            note_fault($sformatf("vertex_count readback: expected %0d, got %0h",
                                 poly_size, got));
        settings_seen++;
    endtask

    // load a fresh polygon, then queries, some at vertices, edges or vertex rows
    task automatic run_phase(int count, int n_queries, bit squeeze);
        coord_t px [MAX_VERTICES];
        coord_t py [MAX_VERTICES];
        coord_t qx, qy;
        int     n, span, k, pick, i, nxt, slot;
        wait_idle();
        set_vertex_count(count);
        n = (count > MAX_VERTICES) ? MAX_VERTICES : count;
        case ($urandom_range(0, 2))
            0:       span = 3;
            1:       span = 40;
            default: span = 8191;
        endcase
        gaps_on    = !squeeze && ($urandom_range(0, 3) != 0);
        sink_style = squeeze ? 0 : $urandom_range(0, 2);
        sink_mask  = 16'($urandom()) | 16'h1;
        @(negedge clk);
        for (k = 0; k < n; k++) begin
            px[k] = rand_coord(span);
            py[k] = rand_coord(span);
            enqueue(MODE_LOAD, k, px[k], py[k]);
        end
        if (squeeze)
            hold_off_req = 1'b1;
        for (k = 0; k < n_queries; k++) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                // stray vertex write in the middle of the queries
                slot = $urandom_range(0, MAX_VERTICES - 1);
                qx   = rand_coord(8191);
                qy   = rand_coord(8191);
                if (slot < n) begin
                    px[slot] = qx;
                    py[slot] = qy;
                end
                enqueue(MODE_LOAD, slot, qx, qy);
            end else begin
                qx = rand_coord(span);
                qy = rand_coord(span);
                if (n >= MIN_POLY) begin
                    i   = $urandom_range(0, n - 1);
                    nxt = (i + 1 == n) ? 0 : i + 1;
                    case (pick)
                        2, 3, 4, 5: begin
                            qx = px[i];
                            qy = py[i];
                        end
                        6, 7, 8: begin
                            qx = coord_t'((int'(px[i]) + int'(px[nxt])) / 2);
                            qy = coord_t'((int'(py[i]) + int'(py[nxt])) / 2);
                        end
                        9, 10, 11: qy = py[i];
                        default: ;
                    endcase
                end
                enqueue(MODE_QUERY, $urandom_range(0, MAX_VERTICES - 1), qx, qy);
            end
        end
    endtask

    initial begin
        request_t r;
        int       base;

        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        item_ch.valid        = 1'b0;
        item_ch.mode         = MODE_LOAD;
        item_ch.vertex_index = '0;
        item_ch.coord_x      = '0;
        item_ch.coord_y      = '0;
        result_ch.ready      = 1'b0;

        // kind            count slot x      y      pinned verdict
        add_step(STEP_QUERY,     0, 0,     0,     0, 1, V_OUTSIDE);
        add_step(STEP_QUERY,     0, 63, 8191, -8192, 1, V_OUTSIDE);
        add_step(STEP_SET_COUNT, 2, 0,     0,     0, 0, V_OUTSIDE);
        add_step(STEP_LOAD,      0, 0, -8192, -8192, 0, V_OUTSIDE);
        add_step(STEP_LOAD,      0, 1,  8191,  8191, 0, V_OUTSIDE);
        add_step(STEP_QUERY,     0, 0,     0,     0, 1, V_OUTSIDE);
        add_step(STEP_SET_COUNT, 4, 0,     0,     0, 0, V_OUTSIDE);
        add_step(STEP_LOAD,      0, 1,  8191, -8192, 0, V_OUTSIDE);
        add_step(STEP_LOAD,      0, 2,  8191,  8191, 0, V_OUTSIDE);
        add_step(STEP_LOAD,      0, 3, -8192,  8191, 0, V_OUTSIDE);
        add_step(STEP_QUERY,     0, 0,     0,     0, 1, V_INSIDE);
        add_step(STEP_QUERY,     0, 0,  8191,     0, 1, V_ON_EDGE);
        add_step(STEP_QUERY,     0, 0, -8192,     0, 0, V_OUTSIDE);
        add_step(STEP_QUERY,     0, 0, -8192, -8192, 0, V_OUTSIDE);
        add_step(STEP_QUERY,     0, 0,     0,  8191, 0, V_OUTSIDE);
        add_step(STEP_QUERY,     0, 42,   -1,    -1, 0, V_OUTSIDE);
        add_step(STEP_SET_COUNT, 3, 0,     0,     0, 0, V_OUTSIDE);
        add_step(STEP_LOAD,      0, 0,     0,     0, 0, V_OUTSIDE);
        add_step(STEP_LOAD,      0, 1,   100,     0, 0, V_OUTSIDE);
        add_step(STEP_LOAD,      0, 2,    50,   100, 0, V_OUTSIDE);
        add_step(STEP_QUERY,     0, 0,   -50,     0, 1, V_OFF_EDGE);
        add_step(STEP_QUERY,     0, 0,    50,    50, 0, V_OUTSIDE);
        add_step(STEP_QUERY,     0, 0,  9000,    50, 0, V_OUTSIDE);
        add_step(STEP_QUERY,     0, 0,    50,   100, 0, V_OUTSIDE);
        add_step(STEP_QUERY,     0, 0, -8192,   100, 0, V_OUTSIDE);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[k]) begin
            if (script[k].kind == STEP_SET_COUNT) begin
                wait_idle();
                set_vertex_count(script[k].value);
            end else begin
                @(negedge clk);
                r.mode    = (script[k].kind == STEP_LOAD) ? MODE_LOAD : MODE_QUERY;
                r.slot    = SLOT_W'(script[k].slot);
                r.x       = coord_t'(script[k].x);
                r.y       = coord_t'(script[k].y);
                r.pinned  = script[k].pinned;
                r.verdict = script[k].verdict;
                pending_q.push_back(r);
                items_queued++;
            end
        end

        base = items_queued;
        run_phase(127, 25, 1'b0);
        run_phase(64, 20, 1'b0);
        run_phase(0, 6, 1'b0);
        run_phase(1, 6, 1'b0);
        run_phase(2, 6, 1'b0);
        run_phase(3, 20, 1'b0);
        run_phase(5, 30, 1'b1);
        while (items_queued - base < ITEM_TARGET)
            run_phase(pick_vertex_count(), $urandom_range(10, 30), 1'b0);

        sink_style = 0;
        wait_idle();

        $display("Ran %0d requests: %0d vertex loads and %0d point queries over %0d count settings,",
                 items_queued, loads_seen, queries_seen, settings_seen);
        $display("%0d queries settled on a polygon edge; %0d faults seen.",
                 edge_verdicts, fault_cnt);
        if (fault_cnt == 0 && verdicts_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
